// ===== rtl/core/fps_pkg.sv =====
// Shared types and constants for the framed byte parser.
package fps_pkg;

  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEAD = 1'b0,
    CFG_END  = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_MISMATCH = 2'd1,
    STAT_SHORT    = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_HUNT,
    S_COLLECT,
    S_READ,
    S_LOAD
  } state_t;

  typedef struct packed {
    logic clear;
    logic store;
    logic load_status;
    logic walk_start;
    logic rd;
    logic load_byte;
  } cmd_t;

  typedef struct packed {
    logic    is_head;
    logic    is_end;
    logic    out_busy;
    logic    out_free;
    logic    emit;
    logic    last;
    status_t code;
  } sts_t;

endpackage

// ===== rtl/core/fps_in_if.sv =====
// Input channel: one received byte per item.
interface fps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/core/fps_out_if.sv =====
// Result channel: payload byte or frame status per item.
interface fps_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic [1:0] frame_status;
  logic       byte_present;
  logic       last_of_frame;

  modport source (output valid, output payload_byte, output frame_status,
                  output byte_present, output last_of_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_status,
                  input byte_present, input last_of_frame, output ready);
endinterface

// ===== rtl/core/framed_byte_parser_sum_check.sv =====
// Top level of the framed byte parser with additive checksum.
// Bytes are taken one per cycle while hunting for the head byte and while
// collecting a frame, as long as the result register is empty. The end byte
// of a frame is judged in the cycle it is taken (the checksum is kept as a
// running sum). A frame that fails, is too short or overflowed gives one
// status item, and input is held until that item is taken. A good frame
// walks the frame store: for each payload byte one memory read (S_READ), then
// one result register load (S_LOAD) that waits out any output backpressure,
// and input is held until the walk ends and its last byte is taken.
module framed_byte_parser_sum_check import fps_pkg::*; #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  fps_in_if.sink               in_chan,
  fps_out_if.source            out_chan
);

  cmd_t cmd;
  sts_t sts;

  fps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fps_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_byte     (in_chan.rx_byte),
    .cmd         (cmd),
    .sts         (sts),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_byte    (out_chan.payload_byte),
    .out_status  (out_chan.frame_status),
    .out_present (out_chan.byte_present),
    .out_last    (out_chan.last_of_frame)
  );

endmodule

// ===== rtl/core/fps_ctrl.sv =====
// Controller state machine: hunt, collect and store walk sequencing.
module fps_ctrl import fps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    acc       = 1'b0;
    unique case (state_r)
      S_HUNT: begin
        in_ready = !sts.out_busy;
        acc      = in_valid && in_ready;
        if (acc && sts.is_head) begin
          cmd.clear = 1'b1;
          state_nxt = S_COLLECT;
        end
      end
      S_COLLECT: begin
        in_ready = !sts.out_busy;
        acc      = in_valid && in_ready;
        if (acc) begin
          if (!sts.is_end) begin
            cmd.store = 1'b1;
          end else if (sts.emit) begin
            cmd.walk_start = 1'b1;
            state_nxt      = S_READ;
          end else begin
            cmd.load_status = 1'b1;
            state_nxt       = S_HUNT;
          end
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.load_byte = 1'b1;
          state_nxt     = sts.last ? S_HUNT : S_READ;
        end
      end
      default: state_nxt = S_HUNT;
    endcase
  end

endmodule

// ===== rtl/core/fps_dp.sv =====
// Datapath: flag registers, frame store, running sum and result register.
module fps_dp import fps_pkg::*; #(
  parameter int FRAME_BYTES = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  input  logic [BYTE_W-1:0]    in_byte,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic [BYTE_W-1:0]    out_byte,
  output logic [1:0]           out_status,
  output logic                 out_present,
  output logic                 out_last
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int SW = BYTE_W + AW;

  logic [BYTE_W-1:0] head_r;
  logic [BYTE_W-1:0] end_r;
  logic [BYTE_W-1:0] mem_r [FRAME_BYTES];
  logic [CW-1:0]     cnt_r;
  logic              ovf_r;
  logic [SW-1:0]     sum_r;
  logic [BYTE_W-1:0] last_byte_r;
  logic [AW-1:0]     rd_idx_r;
  logic [BYTE_W-1:0] rd_data_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  status_t           out_status_r;
  logic              out_present_r;
  logic              out_last_r;
  logic              full;
  logic              match;
  logic [AW-1:0]     plen;

  assign full  = (cnt_r == CW'(FRAME_BYTES));
  assign match = (sum_r == SW'(last_byte_r));
  assign plen  = AW'(cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= BYTE_W'(170);
      end_r  <= BYTE_W'(85);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEAD: head_r <= cfg_data;
        CFG_END:  end_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.clear) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.store) begin
      if (full) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      sum_r <= '0;
    end else if (cmd.store && !full) begin
      if (cnt_r != '0) begin
        sum_r <= sum_r + SW'(last_byte_r);
      end
      last_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && !full) begin
      mem_r[cnt_r[AW-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem_r[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      rd_idx_r <= '0;
    end else if (cmd.load_byte) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_status || cmd.load_byte) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      out_byte_r    <= '0;
      out_status_r  <= sts.code;
      out_present_r <= 1'b0;
      out_last_r    <= 1'b1;
    end else if (cmd.load_byte) begin
      out_byte_r    <= rd_data_r;
      out_status_r  <= STAT_OK;
      out_present_r <= 1'b1;
      out_last_r    <= sts.last;
    end
  end

  always_comb begin
    sts          = '0;
    sts.is_head  = (in_byte == head_r);
    sts.is_end   = (in_byte == end_r);
    sts.out_busy = out_valid_r;
    sts.out_free = !out_valid_r || out_ready;
    sts.last     = (rd_idx_r == plen - AW'(1));
    sts.emit     = !ovf_r && (cnt_r != '0) && match && (plen != '0);
    priority if (ovf_r) begin
      sts.code = STAT_OVERFLOW;
    end else if (cnt_r == '0) begin
      sts.code = STAT_SHORT;
    end else if (!match) begin
      sts.code = STAT_MISMATCH;
    end else begin
      sts.code = STAT_OK;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_byte    = out_byte_r;
  assign out_status  = out_status_r;
  assign out_present = out_present_r;
  assign out_last    = out_last_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FRAME_BYTES))
    else $error("stored count beyond frame size");

  a_present_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_present_r) |-> (out_status_r == STAT_OK))
    else $error("payload byte with failing status");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_status || cmd.load_byte) |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_walk_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> $stable(cnt_r))
    else $error("store changed during walk");
`endif

endmodule
